### rtl/core/mtc_pkg.sv
// Shared types, character codes and letter tables for the Morse text codec.
// No dependencies; imported by every module of the codec.
package mtc_pkg;

  localparam int unsigned NUM_LETTERS = 26;

  localparam logic [7:0] LETTER_BASE = 8'd97;
  localparam logic [7:0] LETTER_END  = 8'd123;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_DASH   = 8'h2D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_NONE   = 8'h00;

  localparam logic [1:0]  WORD_SPACE_RUN = 2'd3;
  localparam logic [1:0]  LETTER_SPACES  = 2'd1;
  localparam logic [1:0]  WORD_SPACES    = 2'd3;
  localparam logic [2:0]  MAX_TOKEN_LEN  = 3'd4;
  localparam logic [2:0]  MAX_GATHER     = 3'd5;
  localparam logic [2:0]  OVERLONG_LEN   = 3'd6;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // symbol count per letter, a..z (x and z use the standard codes)
  localparam logic [2:0] CODE_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // bit i set when symbol i is a dash
  localparam logic [3:0] CODE_BITS [NUM_LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  // one unit of work for the back end: optional token result, then symbols, then spaces
  typedef struct packed {
    logic        has_tok;
    logic        tok_bad;
    logic [7:0]  tok_char;
    logic [2:0]  n_sym;
    logic [3:0]  sym_bits;
    logic [1:0]  n_space;
    logic [15:0] num;
  } job_t;

  typedef struct packed {
    logic       found;
    logic [4:0] idx;
  } lookup_t;

  // token to letter; only tokens of one to four symbols can match
  function automatic lookup_t decode_token(input logic [2:0] len, input logic [4:0] bits);
    lookup_t res;
    res = '0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (!res.found && len == CODE_LEN[i] && bits == {1'b0, CODE_BITS[i]}) begin
        res.found = 1'b1;
        res.idx   = 5'(i);
      end
    end
    return res;
  endfunction

endpackage

### rtl/core/mtc_front.sv
// Front end: holds the mode and token state, classifies each input byte
// and, where it yields results, turns it into a job for the back end. Uses mtc_pkg.
module mtc_front
  import mtc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_mode_i,
  input  logic       accept_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_text_i,
  output logic       job_push_o,
  output job_t       job_o
);

  mode_e       mode_q;
  logic [4:0]  sym_bits_q, sym_bits_d;
  logic [2:0]  sym_len_q, sym_len_d;
  logic [1:0]  space_run_q, space_run_d;
  logic [15:0] tok_count_q, tok_count_d;

  logic        is_letter, is_sym, is_space, finish;
  logic [7:0]  letter_off;
  logic [4:0]  k;
  logic [4:0]  gath_bits;
  logic [2:0]  gath_len;
  logic [4:0]  fin_bits;
  logic [2:0]  fin_len;
  lookup_t     lk;
  job_t        job;

  assign is_letter  = (in_char_i >= LETTER_BASE) && (in_char_i < LETTER_END);
  assign is_sym     = (in_char_i == CHAR_DOT) || (in_char_i == CHAR_DASH);
  assign is_space   = (in_char_i == CHAR_SPACE);
  assign letter_off = in_char_i - LETTER_BASE;
  assign k          = letter_off[4:0];

  // symbol gathered into the pending token
  always_comb begin
    gath_bits = sym_bits_q;
    gath_len  = sym_len_q;
    if (sym_len_q < MAX_GATHER) begin
      if (in_char_i == CHAR_DASH) gath_bits = sym_bits_q | (5'd1 << sym_len_q);
      gath_len = sym_len_q + 3'd1;
    end else begin
      gath_len = OVERLONG_LEN;
    end
  end

  // a separator ends the pending token; end of text ends a token just gathered
  assign finish   = is_sym ? end_of_text_i : (sym_len_q != 3'd0);
  assign fin_bits = is_sym ? gath_bits : sym_bits_q;
  assign fin_len  = is_sym ? gath_len : sym_len_q;
  assign lk       = decode_token(fin_len, fin_bits);

  always_comb begin
    job         = '0;
    sym_bits_d  = sym_bits_q;
    sym_len_d   = sym_len_q;
    space_run_d = space_run_q;
    tok_count_d = tok_count_q;
    if (mode_q == MODE_ENCODE) begin
      if (is_letter) begin
        job.n_sym    = CODE_LEN[k];
        job.sym_bits = CODE_BITS[k];
        job.n_space  = LETTER_SPACES;
      end else if (is_space) begin
        job.n_space  = WORD_SPACES;
      end
    end else begin
      if (finish && tok_count_q != COUNT_MAX) tok_count_d = tok_count_q + 16'd1;
      job.num = tok_count_d;
      if (finish) begin
        job.has_tok  = 1'b1;
        job.tok_bad  = !lk.found;
        job.tok_char = lk.found ? (LETTER_BASE + {3'b0, lk.idx}) : CHAR_NONE;
      end
      if (is_sym) begin
        sym_bits_d  = gath_bits;
        sym_len_d   = gath_len;
        space_run_d = 2'd0;
      end else begin
        sym_bits_d = 5'd0;
        sym_len_d  = 3'd0;
        if (is_space) begin
          if (space_run_q + 2'd1 == WORD_SPACE_RUN) begin
            space_run_d = 2'd0;
            job.n_space = 2'd1;
          end else begin
            space_run_d = space_run_q + 2'd1;
          end
        end else begin
          space_run_d = 2'd0;
        end
      end
      if (end_of_text_i) begin
        sym_bits_d  = 5'd0;
        sym_len_d   = 3'd0;
        space_run_d = 2'd0;
      end
    end
  end

  assign job_o      = job;
  assign job_push_o = accept_i && (job.has_tok || job.n_sym != 3'd0 || job.n_space != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ENCODE;
      sym_bits_q  <= '0;
      sym_len_q   <= '0;
      space_run_q <= '0;
      tok_count_q <= '0;
    end else begin
      if (cfg_we_i) mode_q <= mode_e'(cfg_mode_i);
      if (accept_i) begin
        sym_bits_q  <= sym_bits_d;
        sym_len_q   <= sym_len_d;
        space_run_q <= space_run_d;
        tok_count_q <= tok_count_d;
      end
    end
  end

endmodule

### rtl/core/mtc_job_fifo.sv
// Short job queue between front and back end.
// Uses mtc_pkg for the job type.
module mtc_job_fifo
  import mtc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

### rtl/core/mtc_back.sv
// Back end: expands one job into result items into an output register, one per
// cycle unless a waiting result is not popped. Uses mtc_pkg.
module mtc_back
  import mtc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        bad_token_o,
  output logic [15:0] token_number_o,
  output logic        last_of_run_o
);

  job_t        job_q, job_d;
  logic        job_vld_q;
  logic        out_vld_q;
  logic [7:0]  char_q, res_char;
  logic        bad_q, res_bad;
  logic [15:0] num_q;
  logic        last_q, res_last;
  logic        adv, emit, load;
  logic [3:0]  remain;

  assign adv  = !out_vld_q || pop;
  assign emit = adv && job_vld_q;
  assign load = job_valid_i && (!job_vld_q || (emit && res_last));

  assign remain   = {3'b0, job_q.has_tok} + {1'b0, job_q.n_sym} + {2'b0, job_q.n_space};
  assign res_last = (remain == 4'd1);

  always_comb begin
    job_d    = job_q;
    res_bad  = 1'b0;
    res_char = CHAR_SPACE;
    if (job_q.has_tok) begin
      res_char      = job_q.tok_char;
      res_bad       = job_q.tok_bad;
      job_d.has_tok = 1'b0;
    end else if (job_q.n_sym != 3'd0) begin
      res_char       = job_q.sym_bits[0] ? CHAR_DASH : CHAR_DOT;
      job_d.n_sym    = job_q.n_sym - 3'd1;
      job_d.sym_bits = job_q.sym_bits >> 1;
    end else begin
      job_d.n_space = job_q.n_space - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load)      job_q <= job_i;
    else if (emit) job_q <= job_d;
    if (emit) begin
      char_q <= res_char;
      bad_q  <= res_bad;
      num_q  <= job_q.num;
      last_q <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (load)                  job_vld_q <= 1'b1;
      else if (emit && res_last) job_vld_q <= 1'b0;
      if (adv) out_vld_q <= job_vld_q;
    end
  end

  assign job_pop_o      = load;
  assign empty          = !out_vld_q;
  assign out_char_o     = char_q;
  assign bad_token_o    = bad_q;
  assign token_number_o = num_q;
  assign last_of_run_o  = last_q;

endmodule

### rtl/core/morse_text_codec.sv
// Morse text codec, top level: front end, job queue and back end.
// A result passes through the job queue, the back end's job register and its output register.
// One result per cycle while results are popped; an item holds the back end
// until all its results (up to five) are out, and input is taken every cycle
// while the job queue has room. Reset clears token state, queue and output; mode is encode.
// Depends on mtc_pkg, mtc_front, mtc_job_fifo and mtc_back.
module morse_text_codec
  import mtc_pkg::*;
#(
  parameter int unsigned JOB_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        direction_mode_we_i,
  input  logic        direction_mode_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        bad_token_o,
  output logic [15:0] token_number_o,
  output logic        last_of_run_o
);

  logic accept;
  logic job_push, job_pop, job_valid;
  job_t job_in, job_out;

  assign accept = push && !full;

  mtc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (direction_mode_we_i),
    .cfg_mode_i    (direction_mode_i),
    .accept_i      (accept),
    .in_char_i     (in_char_i),
    .end_of_text_i (end_of_text_i),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  mtc_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  mtc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .empty          (empty),
    .pop            (pop),
    .out_char_o     (out_char_o),
    .bad_token_o    (bad_token_o),
    .token_number_o (token_number_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

### rtl/core/mtc_checker.sv
// Port-level checks on the Morse text codec result side.
// Uses mtc_pkg; bound to morse_text_codec.
module mtc_checker
  import mtc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_char_o,
  input logic        bad_token_o,
  input logic [15:0] token_number_o,
  input logic        last_of_run_o
);

  // a waiting result holds until taken
  a_hold_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_char_o))
    else $error("result char changed while waiting");

  a_hold_meta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(token_number_o) && $stable(last_of_run_o))
    else $error("result fields changed while waiting");

  // an error result carries no character
  a_bad_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && bad_token_o |-> out_char_o == CHAR_NONE)
    else $error("error result with character");

  // a good result is always a printable character
  a_good_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !bad_token_o |-> out_char_o != CHAR_NONE)
    else $error("good result without character");

endmodule

bind morse_text_codec mtc_checker u_mtc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .out_char_o     (out_char_o),
  .bad_token_o    (bad_token_o),
  .token_number_o (token_number_o),
  .last_of_run_o  (last_of_run_o)
);
